FILE: rtl/pexev_pkg.sv
// types and constants shared by the expression evaluator files
package pexev_pkg;

   localparam int unsigned DATA_W = 32;

   // character codes
   localparam logic [7:0] C_PLUS   = 8'h2B;
   localparam logic [7:0] C_MINUS  = 8'h2D;
   localparam logic [7:0] C_STAR   = 8'h2A;
   localparam logic [7:0] C_SLASH  = 8'h2F;
   localparam logic [7:0] C_OPEN   = 8'h28;
   localparam logic [7:0] C_CLOSE  = 8'h29;
   localparam logic [7:0] C_ZERO   = 8'h30;
   localparam logic [7:0] C_NINE   = 8'h39;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } op_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_DIV0,
      ST_PAREN,
      ST_MALFORMED
   } status_type;

   // one saved parenthesis level
   typedef struct packed {
      logic [DATA_W-1:0] acc;
      op_type            op;
      logic              has;
   } lvl_type;

   function automatic op_type char_to_op(input logic [7:0] c);
      op_type r;
      case (c)
         C_PLUS:  r = OP_ADD;
         C_MINUS: r = OP_SUB;
         C_STAR:  r = OP_MUL;
         default: r = OP_DIV;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/pexev_ram.sv
// generic single-write, single-read ram with registered read data
module pexev_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/paren_expression_evaluator.sv
// top level of the character-serial left-to-right expression evaluator
//
//  channel  | dir | payload                                   | handshake
//  ---------+-----+-------------------------------------------+------------------------
//  req_     | in  | tdata[7:0] char_code, tlast end_of_expr   | tvalid / tready
//  rsp_     | out | tdata[31:0] value, tuser[1:0] status      | tvalid / tready
//
// a digit, '(' or ignored code passes accept, decode and end check, an operator also the
// operator set, a ')' close, stack read and parent apply; a pending number adds an apply
// step, each * or / apply runs the 32-step shift-add multiply or restoring divide, ending
// an expression adds check and emit; worst case a final ')' after a number, * or / in both.
// one character at a time; an unread result on rsp_ stalls the input only once the next
// expression ends. sync reset empties the current level; ram levels are written before read.
module paren_expression_evaluator #(
   parameter int MAX_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // end_of_expr
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int LW = $bits(pexev_pkg::lvl_type);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_OPSET,
      S_CLOSE,
      S_POPW,
      S_APPLY,
      S_MUL,
      S_DIV,
      S_END,
      S_CHECK,
      S_EMIT
   } state_type;

   // control
   state_type               state_ff, state_in;
   state_type               ret_ff, ret_in;       // where to go after an operand is applied
   logic [4:0]              cnt_ff, cnt_in;       // serial step count
   // accepted word
   logic [7:0]              char_ff, char_in;
   logic                    last_ff, last_in;
   // current level, its parents live in the ram
   logic [31:0]             acc_ff, acc_in;
   pexev_pkg::op_type       op_ff, op_in;
   logic                    has_ff, has_in;
   logic [31:0]             num_ff, num_in;
   logic                    innum_ff, innum_in;
   logic [DW-1:0]           depth_ff, depth_in;
   pexev_pkg::status_type   err_ff, err_in;
   // serial arithmetic
   logic [31:0]             opnd_ff, opnd_in;     // operand, then divisor magnitude
   logic [31:0]             work_ff, work_in;     // product or remainder
   logic [31:0]             sh_ff, sh_in;         // multiplier or dividend/quotient
   logic                    neg_ff, neg_in;
   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [31:0]             rsp_value_ff, rsp_value_in;
   pexev_pkg::status_type   rsp_status_ff, rsp_status_in;

   // stack ram
   logic                    ram_we;
   logic [AW-1:0]           ram_waddr;
   logic [AW-1:0]           ram_raddr;
   pexev_pkg::lvl_type      push_lvl;
   pexev_pkg::lvl_type      pop_lvl;
   logic [LW-1:0]           ram_rdata;
   logic [DW-1:0]           depth_dec;

   // character classes
   logic                    is_digit;
   logic                    is_op;
   logic [3:0]              digit_val;
   // serial step values
   logic [31:0]             mul_sum;
   logic [32:0]             div_trial;
   logic                    div_ge;
   logic [31:0]             div_q;

   assign depth_dec = depth_ff - DW'(1);
   assign ram_waddr = depth_ff[AW-1:0];
   assign ram_raddr = depth_dec[AW-1:0];
   assign push_lvl  = '{acc: acc_ff, op: op_ff, has: has_ff};
   assign pop_lvl   = pexev_pkg::lvl_type'(ram_rdata);

   pexev_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (push_lvl),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign is_digit  = (char_ff >= pexev_pkg::C_ZERO) && (char_ff <= pexev_pkg::C_NINE);
   assign is_op     = (char_ff == pexev_pkg::C_PLUS) || (char_ff == pexev_pkg::C_MINUS)
                   || (char_ff == pexev_pkg::C_STAR) || (char_ff == pexev_pkg::C_SLASH);
   assign digit_val = 4'(char_ff - pexev_pkg::C_ZERO);

   // one shift-add step of the multiply
   assign mul_sum   = work_ff + (sh_ff[0] ? acc_ff : 32'd0);
   // one restoring step of the divide
   assign div_trial = {work_ff, sh_ff[31]};
   assign div_ge    = div_trial >= {1'b0, opnd_ff};
   assign div_q     = {sh_ff[30:0], div_ge};

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      cnt_in        = cnt_ff;
      char_in       = char_ff;
      last_in       = last_ff;
      acc_in        = acc_ff;
      op_in         = op_ff;
      has_in        = has_ff;
      num_in        = num_ff;
      innum_in      = innum_ff;
      depth_in      = depth_ff;
      err_in        = err_ff;
      opnd_in       = opnd_ff;
      work_in       = work_ff;
      sh_in         = sh_ff;
      neg_in        = neg_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      ram_we        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               char_in  = req_tdata;
               last_in  = req_tlast;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            state_in = S_END;
            if (err_ff == pexev_pkg::ST_OK) begin
               if (is_digit) begin
                  if (!innum_ff && has_ff) begin
                     err_in = pexev_pkg::ST_MALFORMED;
                  end else begin
                     innum_in = 1'b1;
                     num_in   = {num_ff[28:0], 3'b000} + {num_ff[30:0], 1'b0}
                              + {28'd0, digit_val};
                  end
               end else if (is_op || (char_ff == pexev_pkg::C_CLOSE)) begin
                  // a pending number is applied first
                  ret_in = is_op ? S_OPSET : S_CLOSE;
                  if (innum_ff) begin
                     opnd_in  = num_ff;
                     innum_in = 1'b0;
                     num_in   = '0;
                     state_in = S_APPLY;
                  end else begin
                     state_in = is_op ? S_OPSET : S_CLOSE;
                  end
               end else if (char_ff == pexev_pkg::C_OPEN) begin
                  if (innum_ff || has_ff) begin
                     err_in = pexev_pkg::ST_MALFORMED;
                  end else if (depth_ff >= DW'(MAX_DEPTH)) begin
                     err_in = pexev_pkg::ST_PAREN;
                  end else begin
                     ram_we   = 1'b1;
                     depth_in = depth_ff + DW'(1);
                     acc_in   = '0;
                     op_in    = pexev_pkg::OP_ADD;
                     has_in   = 1'b0;
                  end
               end
            end
         end

         S_OPSET: begin
            state_in = S_END;
            if (err_ff == pexev_pkg::ST_OK) begin
               if (!has_ff) begin
                  err_in = pexev_pkg::ST_MALFORMED;
               end else begin
                  op_in  = pexev_pkg::char_to_op(char_ff);
                  has_in = 1'b0;
               end
            end
         end

         S_CLOSE: begin
            state_in = S_END;
            if (err_ff == pexev_pkg::ST_OK) begin
               if (depth_ff == '0) begin
                  err_in = pexev_pkg::ST_PAREN;
               end else if (!has_ff) begin
                  err_in = pexev_pkg::ST_MALFORMED;
               end else begin
                  // inner value becomes the operand of the parent level
                  opnd_in  = acc_ff;
                  depth_in = depth_dec;
                  state_in = S_POPW;
               end
            end
         end

         S_POPW: begin
            acc_in   = pop_lvl.acc;
            op_in    = pop_lvl.op;
            has_in   = pop_lvl.has;
            ret_in   = S_END;
            state_in = S_APPLY;
         end

         S_APPLY: begin
            cnt_in  = '0;
            work_in = '0;
            case (op_ff)
               pexev_pkg::OP_ADD: begin
                  acc_in   = acc_ff + opnd_ff;
                  has_in   = 1'b1;
                  state_in = ret_ff;
               end
               pexev_pkg::OP_SUB: begin
                  acc_in   = acc_ff - opnd_ff;
                  has_in   = 1'b1;
                  state_in = ret_ff;
               end
               pexev_pkg::OP_MUL: begin
                  sh_in    = opnd_ff;
                  state_in = S_MUL;
               end
               default: begin
                  if (opnd_ff == '0) begin
                     err_in   = pexev_pkg::ST_DIV0;
                     state_in = ret_ff;
                  end else begin
                     neg_in   = acc_ff[31] ^ opnd_ff[31];
                     sh_in    = acc_ff[31] ? (~acc_ff + 32'd1) : acc_ff;
                     opnd_in  = opnd_ff[31] ? (~opnd_ff + 32'd1) : opnd_ff;
                     state_in = S_DIV;
                  end
               end
            endcase
         end

         S_MUL: begin
            work_in = mul_sum;
            acc_in  = {acc_ff[30:0], 1'b0};
            sh_in   = {1'b0, sh_ff[31:1]};
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               acc_in   = mul_sum;
               has_in   = 1'b1;
               state_in = ret_ff;
            end
         end

         S_DIV: begin
            // the remainder stays below the divisor, so 32 bits hold it
            work_in = div_ge ? (div_trial[31:0] - opnd_ff) : div_trial[31:0];
            sh_in   = div_q;
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               acc_in   = neg_ff ? (~div_q + 32'd1) : div_q;
               has_in   = 1'b1;
               state_in = ret_ff;
            end
         end

         S_END: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if ((err_ff == pexev_pkg::ST_OK) && innum_ff) begin
               opnd_in  = num_ff;
               innum_in = 1'b0;
               num_in   = '0;
               ret_in   = S_CHECK;
               state_in = S_APPLY;
            end else begin
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            if (err_ff == pexev_pkg::ST_OK) begin
               if (depth_ff != '0) begin
                  err_in = pexev_pkg::ST_PAREN;
               end else if (!has_ff) begin
                  err_in = pexev_pkg::ST_MALFORMED;
               end
            end
            state_in = S_EMIT;
         end

         S_EMIT: begin
            // hold here only while an earlier result is still unread
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = (err_ff == pexev_pkg::ST_OK) ? acc_ff : 32'd0;
               rsp_status_in = err_ff;
               acc_in        = '0;
               op_in         = pexev_pkg::OP_ADD;
               has_in        = 1'b0;
               num_in        = '0;
               innum_in      = 1'b0;
               depth_in      = '0;
               err_in        = pexev_pkg::ST_OK;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_END;
         cnt_ff       <= '0;
         acc_ff       <= '0;
         op_ff        <= pexev_pkg::OP_ADD;
         has_ff       <= 1'b0;
         num_ff       <= '0;
         innum_ff     <= 1'b0;
         depth_ff     <= '0;
         err_ff       <= pexev_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         cnt_ff       <= cnt_in;
         acc_ff       <= acc_in;
         op_ff        <= op_in;
         has_ff       <= has_in;
         num_ff       <= num_in;
         innum_ff     <= innum_in;
         depth_ff     <= depth_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff       <= char_in;
      last_ff       <= last_in;
      opnd_ff       <= opnd_in;
      work_ff       <= work_in;
      sh_ff         <= sh_in;
      neg_ff        <= neg_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

FILE: rtl/pexev_checker.sv
// port-level checks for the expression evaluator, bound to the top level
module pexev_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // an error result carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != pexev_pkg::ST_OK) |-> rsp_tdata == 32'd0)
      else $error("error result with nonzero value");

   // one character at a time: no acceptance in the cycle after one
   a_one_char: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("characters accepted back to back");

   // nothing is offered straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind paren_expression_evaluator pexev_checker u_pexev_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: sim/pexev_checker.sv
// result checker for the expression evaluator: predicts every result word and compares it
module pexev_scoreboard #(
   parameter int MAX_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          errors,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0]           value;
      pexev_pkg::status_type status;
   } expr_result_type;

   // predicted evaluator state, one entry per parenthesis level
   logic [31:0]           lvl_acc [0:MAX_DEPTH];
   pexev_pkg::op_type     lvl_op  [0:MAX_DEPTH];
   bit                    lvl_has [0:MAX_DEPTH];
   logic [31:0]           num_acc;
   bit                    in_num;
   int unsigned           nest;
   pexev_pkg::status_type err;

   expr_result_type results_due[$];
   int              fail_count = 0;

   assign errors = fail_count;

   function automatic void clear_all();
      for (int i = 0; i <= MAX_DEPTH; i++) begin
         lvl_acc[i] = '0;
         lvl_op[i]  = pexev_pkg::OP_ADD;
         lvl_has[i] = 1'b0;
      end
      num_acc = '0;
      in_num  = 1'b0;
      nest    = 0;
      err     = pexev_pkg::ST_OK;
   endfunction

   function automatic void flag_error(input pexev_pkg::status_type s);
      if (err == pexev_pkg::ST_OK)
         err = s;
   endfunction

   // signed quotient truncated toward zero, wrapping for the most negative / -1
   function automatic logic [31:0] quot_trunc(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q  = ma / mb;
      return (a[31] ^ b[31]) ? -q : q;
   endfunction

   function automatic void combine(input int unsigned lv, input logic [31:0] operand);
      logic [31:0] acc;
      acc = lvl_acc[lv];
      case (lvl_op[lv])
         pexev_pkg::OP_ADD: acc = acc + operand;
         pexev_pkg::OP_SUB: acc = acc - operand;
         pexev_pkg::OP_MUL: acc = acc * operand;
         default: begin
            if (operand == '0) begin
               flag_error(pexev_pkg::ST_DIV0);
               return;
            end
            acc = quot_trunc(acc, operand);
         end
      endcase
      lvl_acc[lv] = acc;
      lvl_has[lv] = 1'b1;
   endfunction

   function automatic void close_number();
      if (in_num) begin
         in_num = 1'b0;
         combine(nest, num_acc);
         num_acc = '0;
      end
   endfunction

   function automatic void step_char(input logic [7:0] c);
      int unsigned d;
      d = nest;
      if (c >= pexev_pkg::C_ZERO && c <= pexev_pkg::C_NINE) begin
         if (!in_num && lvl_has[d]) begin
            flag_error(pexev_pkg::ST_MALFORMED);
            return;
         end
         in_num  = 1'b1;
         num_acc = num_acc * 32'd10 + (c - pexev_pkg::C_ZERO);
      end else if (c == pexev_pkg::C_PLUS || c == pexev_pkg::C_MINUS ||
                   c == pexev_pkg::C_STAR || c == pexev_pkg::C_SLASH) begin
         close_number();
         if (err != pexev_pkg::ST_OK)
            return;
         if (!lvl_has[d]) begin
            flag_error(pexev_pkg::ST_MALFORMED);
            return;
         end
         case (c)
            pexev_pkg::C_PLUS:  lvl_op[d] = pexev_pkg::OP_ADD;
            pexev_pkg::C_MINUS: lvl_op[d] = pexev_pkg::OP_SUB;
            pexev_pkg::C_STAR:  lvl_op[d] = pexev_pkg::OP_MUL;
            default:            lvl_op[d] = pexev_pkg::OP_DIV;
         endcase
         lvl_has[d] = 1'b0;
      end else if (c == pexev_pkg::C_OPEN) begin
         if (in_num || lvl_has[d]) begin
            flag_error(pexev_pkg::ST_MALFORMED);
            return;
         end
         if (d >= MAX_DEPTH) begin
            flag_error(pexev_pkg::ST_PAREN);
            return;
         end
         nest = d + 1;
         lvl_acc[d+1] = '0;
         lvl_op[d+1]  = pexev_pkg::OP_ADD;
         lvl_has[d+1] = 1'b0;
      end else if (c == pexev_pkg::C_CLOSE) begin
         close_number();
         if (err != pexev_pkg::ST_OK)
            return;
         if (d == 0) begin
            flag_error(pexev_pkg::ST_PAREN);
            return;
         end
         if (!lvl_has[d]) begin
            flag_error(pexev_pkg::ST_MALFORMED);
            return;
         end
         nest = d - 1;
         combine(d - 1, lvl_acc[d]);
      end
   endfunction

   function automatic void take_char(input logic [7:0] c, input logic last);
      expr_result_type r;
      if (err == pexev_pkg::ST_OK)
         step_char(c);
      if (last) begin
         if (err == pexev_pkg::ST_OK)
            close_number();
         if (err == pexev_pkg::ST_OK) begin
            if (nest != 0)
               flag_error(pexev_pkg::ST_PAREN);
            else if (!lvl_has[0])
               flag_error(pexev_pkg::ST_MALFORMED);
         end
         r.value  = (err == pexev_pkg::ST_OK) ? lvl_acc[0] : '0;
         r.status = err;
         results_due = {results_due, r};
         clear_all();
      end
   endfunction

   function automatic void note_fail(input string what, input bit known,
                                     input expr_result_type want);
      fail_count++;
      if (fail_count <= 10) begin
         if (known)
            $display("%0t %s: expected value %0d status %s, got value %0d status %0d",
                     $realtime, what, $signed(want.value), want.status.name(),
                     $signed(rsp_tdata), rsp_tuser);
         else
            $display("%0t %s: nothing expected, got value %0d status %0d",
                     $realtime, what, $signed(rsp_tdata), rsp_tuser);
      end
   endfunction

   always @(posedge clock) begin : watch
      expr_result_type want;
      if (reset) begin
         clear_all();
         results_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               want = '0;
               note_fail("unexpected result word", 1'b0, want);
            end else begin
               want = results_due.pop_front();
               if (rsp_tdata !== want.value || rsp_tuser !== want.status)
                  note_fail("result mismatch", 1'b1, want);
            end
         end
         if (req_tvalid && req_tready)
            take_char(req_tdata, req_tlast);
      end
      outstanding <= results_due.size();
   end

endmodule

FILE: sim/tb_paren_expression_evaluator.sv
// testbench top for the expression evaluator: stimulus, flow control and verdict
module tb_paren_expression_evaluator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = 16;
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_CHARS = 560;
   // slowest run: ~850 words each on its slowest path, the longest gap on each side and the
   // long receiver hold, so this limit is several times over
   localparam int RUN_LIMIT    = 1_000_000;
   localparam int LONG_HOLD    = 600;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] char_code
   logic        req_tlast  = 1'b0; // end_of_expr
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [31:0] value
   logic [1:0]  rsp_tuser;         // [1:0] status

   int          errors;
   int          outstanding;
   int unsigned cycle_count = 0;
   int          chars_sent  = 0;   // words the block acts on; ignored codes not counted
   bit          sender_gaps = 1'b1;

   logic [7:0]  expr_chars[$];     // expression being built before it is sent

   paren_expression_evaluator #(
      .MAX_DEPTH(DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // watches both channels, predicts and compares
   pexev_scoreboard #(
      .MAX_DEPTH(DEPTH)
   ) u_scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .errors      (errors),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   initial begin
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[paren_expression_evaluator] ERROR");
      $finish;
   end

   // idle length: mostly short, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic bit is_meaningful(input logic [7:0] c);
      return (c >= pexev_pkg::C_ZERO && c <= pexev_pkg::C_NINE) ||
             c == pexev_pkg::C_PLUS || c == pexev_pkg::C_MINUS ||
             c == pexev_pkg::C_STAR || c == pexev_pkg::C_SLASH ||
             c == pexev_pkg::C_OPEN || c == pexev_pkg::C_CLOSE;
   endfunction

   // a code the block must ignore, drawn from the whole byte range
   function automatic logic [7:0] noise_char();
      logic [7:0] c;
      do
         c = 8'($urandom_range(0, 255));
      while (is_meaningful(c));
      return c;
   endfunction

   function automatic logic [7:0] pick_op();
      case ($urandom_range(0, 3))
         0:       return pexev_pkg::C_PLUS;
         1:       return pexev_pkg::C_MINUS;
         2:       return pexev_pkg::C_STAR;
         default: return pexev_pkg::C_SLASH;
      endcase
   endfunction

   // any token at all, used to break well-formed expressions
   function automatic logic [7:0] any_token();
      case ($urandom_range(0, 5))
         0, 1:    return pexev_pkg::C_ZERO + 8'($urandom_range(0, 9));
         2, 3:    return pick_op();
         4:       return pexev_pkg::C_OPEN;
         default: return pexev_pkg::C_CLOSE;
      endcase
   endfunction

   // ---------------------------------------------------------------------------------
   // sender side: one word per call, with an occasional gap after acceptance
   // ---------------------------------------------------------------------------------
   task automatic send_word(input logic [7:0] c, input logic last);
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do
         @(posedge clock);
      while (!req_tready);
      if (is_meaningful(c))
         chars_sent++;
      // valid is only dropped when a gap follows, never lowered and raised in one step
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_word(s[i], i == s.len() - 1);
   endtask

   // sends the built expression, the last word carrying tlast
   task automatic send_expr();
      if (expr_chars.size() == 0)
         expr_chars = {expr_chars, noise_char()};
      foreach (expr_chars[i])
         send_word(expr_chars[i], i == expr_chars.size() - 1);
      expr_chars.delete();
   endtask

   // holds the sender until every predicted result has come back
   task automatic wait_drained();
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------
   // expression generator: well-formed left-to-right chains, nested at random
   // ---------------------------------------------------------------------------------
   task automatic add_char(input logic [7:0] c);
      expr_chars = {expr_chars, c};
      // ignored codes must neither split a number nor disturb anything else
      if ($urandom_range(0, 19) == 0)
         expr_chars = {expr_chars, noise_char()};
   endtask

   task automatic gen_number();
      int n;
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 11) : $urandom_range(1, 3);
      repeat (n) add_char(pexev_pkg::C_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task automatic gen_operand(input int lv);
      if (lv < DEPTH && $urandom_range(0, 3) == 0) begin
         add_char(pexev_pkg::C_OPEN);
         gen_chain(lv + 1);
         add_char(pexev_pkg::C_CLOSE);
      end else begin
         gen_number();
      end
   endtask

   task automatic gen_chain(input int lv);
      gen_operand(lv);
      repeat ($urandom_range(0, 3)) begin
         add_char(pick_op());
         gen_operand(lv);
      end
   endtask

   // n nested levels around one number, with short tails on the way out;
   // one past the stack size has to come back as a nesting error
   task automatic gen_deep(input int n);
      repeat (n) add_char(pexev_pkg::C_OPEN);
      gen_number();
      repeat (n) begin
         if ($urandom_range(0, 2) == 0) begin
            add_char(pick_op());
            gen_number();
         end
         add_char(pexev_pkg::C_CLOSE);
      end
   endtask

   // one random edit: replace, drop, insert or cut short
   task automatic break_expr();
      int pos;
      if (expr_chars.size() == 0)
         return;
      pos = $urandom_range(0, expr_chars.size() - 1);
      case ($urandom_range(0, 3))
         0: expr_chars[pos] = any_token();
         1: expr_chars.delete(pos);
         2: expr_chars.insert(pos, any_token());
         default: begin
            while (expr_chars.size() > pos)
               void'(expr_chars.pop_back());
         end
      endcase
   endtask

   // ---------------------------------------------------------------------------------
   // receiver side: random back-pressure, calm stretches, one long hold-off
   // ---------------------------------------------------------------------------------
   initial begin : receiver
      int gap;
      int rsp_seen;
      bit calm;
      bit long_done;
      gap       = 0;
      rsp_seen  = 0;
      calm      = 1'b0;
      long_done = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            rsp_seen++;
         if (cycle_count % 300 == 0)
            calm = ($urandom_range(0, 2) == 0);
         if (!long_done && rsp_seen >= 30) begin
            // long stall while the sender keeps going: the result stays parked and
            // the next end-of-expression word has to back up the input
            long_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (gap > 0) begin
            rsp_tready <= 1'b0;
            gap--;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 4) == 0)
               gap = pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------------
   initial begin : stimulus
      int r;
      int stop_at;
      bit paused;
      paused = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, every operator and each corner of the grammar
      send_text("42");
      send_text("4294967295+1");          // wraps to zero
      send_text("4294967296");            // number wraps while being read
      send_text("2147483647*2+3");        // multiply wraps
      send_text("7-9*3");                 // strictly left to right, negative result
      send_text("(0-7)/2");               // division truncates toward zero
      send_text("2147483648/(0-1)");      // most negative over minus one
      send_text("9/0");                   // divide by zero
      send_text("1/0)");                  // sticky error, later close ignored
      send_text("12 3+4 ");               // ignored code inside a number and at the end
      send_word(8'h31, 1'b0);             // all-ones code ignored too
      send_word(8'hFF, 1'b0);
      send_word(8'h32, 1'b1);
      send_word(8'h00, 1'b1);             // empty expression
      send_text(")");                     // close at top level
      send_text("(1");                    // open left unclosed
      send_text("+1");                    // leading operator
      send_text("1++2");                  // two operators in a row
      send_text("(+1)");                  // operator right after open
      send_text("1+");                    // operand missing at the end
      send_text("()");                    // empty parentheses
      send_text("1(");                    // open right after a number
      send_text("(1)2");                  // digit right after close
      send_text("(1)(2)");                // open right after close
      gen_deep(DEPTH);                    // full stack
      send_expr();
      gen_deep(DEPTH + 1);                // one level too deep
      send_expr();

      // random: mostly well-formed chains, some deep ones, some broken or pure noise
      stop_at = chars_sent + RANDOM_CHARS;
      while (chars_sent < stop_at) begin
         sender_gaps = ($urandom_range(0, 2) != 0);
         if (!paused && chars_sent > stop_at - RANDOM_CHARS / 2) begin
            // let the block run completely dry once
            paused = 1'b1;
            req_tvalid <= 1'b0;
            wait_drained();
         end
         r = $urandom_range(0, 99);
         if (r < 5) begin
            repeat ($urandom_range(1, 6))
               expr_chars = {expr_chars, 8'($urandom_range(0, 255))};
         end else if (r < 12) begin
            gen_deep($urandom_range(10, DEPTH + 1));
         end else begin
            gen_chain(0);
         end
         if ($urandom_range(0, 4) == 0)
            break_expr();
         send_expr();
      end

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (60) @(posedge clock);
      if (errors == 0)
         $display("[paren_expression_evaluator] OK");
      else
         $display("[paren_expression_evaluator] ERROR");
      $finish;
   end

endmodule

FILE: paren_expression_evaluator.f
rtl/pexev_pkg.sv
rtl/pexev_ram.sv
rtl/paren_expression_evaluator.sv
rtl/pexev_checker.sv
sim/pexev_checker.sv
sim/tb_paren_expression_evaluator.sv
